[src/sidec_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sidec_pkg - shared types and constants of the decimal text converter
// Widths, character codes, the power-of-ten table and the command and
// status groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package sidec_pkg;

    localparam int unsigned NUM_POS = 10;   // decimal positions of a 32-bit magnitude
    localparam int unsigned POS_W   = 4;
    localparam int unsigned MAG_W   = 32;
    localparam int unsigned STEP_W  = 34;   // holds nine times ten to the ninth
    localparam int unsigned CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 6'd57;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 6'd45;

    localparam logic [POS_W-1:0] FIRST_POS = 4'd9;
    localparam logic [POS_W-1:0] LAST_POS  = 4'd0;

    // Power of ten for each position, least significant position first.
    localparam logic [STEP_W-1:0] POW10 [NUM_POS] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    typedef struct packed {
        logic             load;      // take a new value into the magnitude register
        logic             emit;      // write a character into the output register
        logic             sel_sign;  // the character is the minus sign
        logic             last;      // the character ends the text
        logic             update;    // remove the current digit from the magnitude
        logic [POS_W-1:0] pos;       // decimal position being resolved
    } sidec_cmd_t;

    typedef struct packed {
        logic neg;         // the value being converted is negative
        logic digit_zero;  // the digit at the current position is zero
        logic out_free;    // the output register can take a character
    } sidec_status_t;

endpackage
`default_nettype wire

[src/sidec_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sidec_dp - datapath of the decimal text converter
// Holds the magnitude, resolves one decimal digit per cycle unless its
// character must wait for the output register, by comparison against the
// multiples of the position's power of ten, and drives the output register.
// ---------------------------------------------------------------------------
module sidec_dp
    import sidec_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [31:0] s_value,
    input  wire sidec_cmd_t         cmd,
    output sidec_status_t           status,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CHAR_W-1:0]       m_ascii_char,
    output logic                    m_last_char
);

    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic [STEP_W-1:0] pow;
    logic [STEP_W-1:0] thr [NUM_POS];
    logic [3:0]        digit;
    logic [MAG_W-1:0]  in_bits;

    // Multiples of the power of ten; the digit is the largest multiple not
    // above the magnitude.
    always_comb begin
        pow   = POW10[cmd.pos];
        digit = 4'd0;
        for (int d = 0; d < NUM_POS; d++) begin
            thr[d] = pow * STEP_W'(d);
        end
        for (int d = 1; d < NUM_POS; d++) begin
            if ({2'b00, mag_reg} >= thr[d]) begin
                digit = 4'(d);
            end
        end
    end

    assign in_bits = MAG_W'(s_value);

    always_comb begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        if (cmd.load) begin
            neg_next = in_bits[MAG_W-1];
            mag_next = in_bits[MAG_W-1] ? (~in_bits + 32'd1) : in_bits;
        end else if (cmd.update) begin
            mag_next = mag_reg - thr[digit][MAG_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            char_next    = cmd.sel_sign ? MINUS_CHAR : (DIGIT_ZERO + {2'b00, digit});
            last_next    = cmd.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg        = neg_reg;
    assign status.digit_zero = (digit == 4'd0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = char_reg;
    assign m_last_char  = last_reg;

`ifndef SYNTHESIS
    // A character is never written over a beat that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("sidec_dp: character written over a pending beat");

    // The minus sign never ends a text.
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && char_reg == MINUS_CHAR) |-> !last_reg)
        else $error("sidec_dp: minus sign flagged as last");

    // Every character shown is the minus sign or a decimal digit.
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (char_reg == MINUS_CHAR
                         || (char_reg >= DIGIT_ZERO && char_reg <= DIGIT_NINE)))
        else $error("sidec_dp: illegal character code");
`endif

endmodule
`default_nettype wire

[src/sidec_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sidec_ctrl - controller of the decimal text converter
// Sequences the load, the optional minus sign and the ten decimal
// positions, suppressing leading zeros.
// ---------------------------------------------------------------------------
module sidec_ctrl
    import sidec_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sidec_status_t status,
    output sidec_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SIGN  = 3'b010,
        ST_DIGIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             lead_reg, lead_next;

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        lead_next    = lead_reg;
        cmd          = '0;
        cmd.pos      = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pos_next   = FIRST_POS;
                    lead_next  = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!status.neg) begin
                    state_next = ST_DIGIT;
                end else if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.sel_sign = 1'b1;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (lead_reg && status.digit_zero && pos_reg != LAST_POS) begin
                    pos_next = pos_reg - 4'd1;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.update = 1'b1;
                    cmd.last   = (pos_reg == LAST_POS);
                    lead_next  = 1'b0;
                    if (pos_reg == LAST_POS) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 4'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= FIRST_POS;
            lead_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            lead_reg  <= lead_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

[src/signed_int_to_decimal_ascii_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit - signed integer to decimal ASCII text
// Converts each 32-bit two's complement value into its decimal characters,
// most significant first, with a leading minus sign for negative values.
// ---------------------------------------------------------------------------
// A value is taken on the s_ channel and its text leaves on the m_ channel as
// one character per beat: a minus sign for a negative value, then the digits
// with leading zeros suppressed, so zero gives the single character '0' and
// the most negative value gives '-' and the ten digits of 2147483648. The
// final beat of each text carries m_last_char. One value is converted at a
// time, in order: the load of the magnitude, the sign position (a character
// only when the value is negative) and then each of the ten decimal
// positions, of which only the significant ones produce a beat. The digit
// unit resolves one decimal position per cycle while the output is not
// stalled, by comparing the magnitude with the nine multiples of that
// position's power of ten and subtracting the chosen multiple. A character
// that finds the output register still holding an untaken beat waits;
// stalls that fall on the load cycle or on skipped leading zeros cost nothing.
// The output register lets the next value be taken while the last character
// of the previous text still waits for m_ready.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sidec_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CHAR_W-1:0]       m_ascii_char,
    output logic                    m_last_char
);

    // Commands from the sequencer and status back from the datapath.
    sidec_cmd_t    cmd;
    sidec_status_t status;

    sidec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sidec_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last_char  (m_last_char)
    );

endmodule
`default_nettype wire
